@@ design/spq_pkg.sv @@
package spq_pkg;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  key;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t item;
  } cell_ctrl_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] served_id;
    logic [7:0]  served_key;
  } result_t;

endpackage

@@ design/spq_if.sv @@
interface spq_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] entry_id;
  logic [7:0]  entry_key;

  modport source (output valid, output kind, output entry_id, output entry_key, input ready);
  modport sink (input valid, input kind, input entry_id, input entry_key, output ready);
endinterface

interface spq_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] served_id;
  logic [7:0]  served_key;

  modport source (output valid, output status, output served_id, output served_key,
                  input ready);
  modport sink (input valid, input status, input served_id, input served_key, output ready);
endinterface

@@ design/sorted_priority_queue.sv @@
// channel  dir  handshake     payload
// req      in   valid/ready   kind, entry_id, entry_key
// rsp      out  valid/ready   status, served_id, served_key
//
// one transaction per cycle: every cell of the chain compares and shifts in
// the same cycle, the result lands in a two-slot output buffer.
// req.ready drops only while both output slots are occupied.
// synchronous reset empties the queue and the output buffer.
module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = 8
) (
  input logic clk,
  input logic rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);

  localparam int OW = $clog2(QUEUE_DEPTH + 1);

  logic [OW-1:0]       occ;
  logic [OW-1:0]       occ_next;
  logic                accept;
  logic                full;
  logic                empty;
  logic                can_push;
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::result_t    res;
  spq_pkg::result_t    rsp_data;
  spq_pkg::entry_t     cell_data [QUEUE_DEPTH];
  logic                cell_after [QUEUE_DEPTH];

  assign req.ready = can_push;
  assign accept    = req.valid && req.ready;
  assign full      = (occ == OW'(QUEUE_DEPTH));
  assign empty     = (occ == '0);

  always_comb begin
    ctrl.item.id  = req.entry_id;
    ctrl.item.key = req.entry_key;
    ctrl.ins      = accept && (req.kind == spq_pkg::KIND_INSERT) && !full;
    ctrl.rem      = accept && (req.kind == spq_pkg::KIND_REMOVE) && !empty;

    occ_next = occ;
    if (ctrl.ins) begin
      occ_next = occ + OW'(1);
    end else if (ctrl.rem) begin
      occ_next = occ - OW'(1);
    end

    res.status     = spq_pkg::ST_DONE;
    res.served_id  = '0;
    res.served_key = '0;
    if (req.kind == spq_pkg::KIND_INSERT) begin
      if (full) begin
        res.status = spq_pkg::ST_FULL;
      end
    end else if (empty) begin
      res.status = spq_pkg::ST_EMPTY;
    end else begin
      res.served_id  = cell_data[0].id;
      res.served_key = cell_data[0].key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ_next;
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left_d;
    logic            left_a;
    spq_pkg::entry_t right_d;

    if (i == 0) begin : g_first
      assign left_d = ctrl.item;
      assign left_a = 1'b0;
    end else begin : g_mid
      assign left_d = cell_data[i-1];
      assign left_a = cell_after[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_inner
      assign right_d = cell_data[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .valid      (occ > OW'(i)),
      .left       (left_d),
      .left_after (left_a),
      .right      (right_d),
      .after      (cell_after[i]),
      .data       (cell_data[i])
    );
  end

  spq_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  (rsp_data)
  );

  assign rsp.status     = rsp_data.status;
  assign rsp.served_id  = rsp_data.served_id;
  assign rsp.served_key = rsp_data.served_key;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OW'(QUEUE_DEPTH))
    else $error("occupancy beyond depth");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    accept && (req.kind == spq_pkg::KIND_INSERT) && full |=> occ == $past(occ))
    else $error("refused insert changed occupancy");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    occ >= OW'(2) |-> cell_data[0].key >= cell_data[1].key)
    else $error("head out of order");

  a_rem_step: assert property (@(posedge clk) disable iff (rst)
    ctrl.rem |=> occ == $past(occ) - OW'(1))
    else $error("removal did not shrink queue");
`endif

endmodule

@@ design/spq_cell.sv @@
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic               valid,
  input  spq_pkg::entry_t    left,
  input  logic               left_after,
  input  spq_pkg::entry_t    right,
  output logic               after,
  output spq_pkg::entry_t    data
);

  spq_pkg::entry_t data_next;

  // this slot lies at or past the insert position
  assign after = !(valid && (data.key >= ctrl.item.key));

  always_comb begin
    data_next = data;
    if (ctrl.ins && after) begin
      data_next = left_after ? left : ctrl.item;
    end else if (ctrl.rem) begin
      data_next = right;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

@@ design/spq_out_buf.sv @@
module spq_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  spq_pkg::result_t push_data,
  output logic             can_push,
  output logic             out_valid,
  input  logic             out_ready,
  output spq_pkg::result_t out_data
);

  logic [1:0]       cnt;
  logic [1:0]       cnt_next;
  logic [1:0]       cnt_after_pop;
  logic             pop;
  spq_pkg::result_t slot0;
  spq_pkg::result_t slot1;
  spq_pkg::result_t slot0_next;
  spq_pkg::result_t slot1_next;

  assign can_push  = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_data  = slot0;
  assign pop       = out_valid && out_ready;

  always_comb begin
    cnt_after_pop = cnt - {1'b0, pop};
    cnt_next      = cnt_after_pop + {1'b0, push};
    slot0_next    = pop ? slot1 : slot0;
    slot1_next    = slot1;
    if (push) begin
      if (cnt_after_pop == 2'd0) begin
        slot0_next = push_data;
      end else begin
        slot1_next = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    slot0 <= slot0_next;
    slot1 <= slot1_next;
  end

endmodule

@@ test/spq_checker.sv @@
module spq_checker #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  spq_req_if          req,
  spq_rsp_if          rsp,
  output int unsigned failures,
  output int unsigned pending,
  output int unsigned requests_seen,
  output int unsigned served_count,
  output int unsigned full_count,
  output int unsigned empty_count,
  output int unsigned peak_fill
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the queue contents, slot 0 leaves next
  spq_pkg::entry_t  slots [QUEUE_DEPTH];
  int unsigned      fill;
  spq_pkg::result_t expected_results[$];

  int unsigned fail_count;
  int unsigned request_count;
  int unsigned result_count;
  int unsigned serve_count;
  int unsigned refuse_full;
  int unsigned refuse_empty;
  int unsigned fill_peak;

  function automatic spq_pkg::result_t apply_request(logic kind, logic [15:0] id,
                                                     logic [7:0] key);
    spq_pkg::result_t r;
    int               pos;
    r.status     = spq_pkg::ST_DONE;
    r.served_id  = '0;
    r.served_key = '0;
    if (kind == spq_pkg::KIND_INSERT) begin
      if (fill >= QUEUE_DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        // walk past every held entry with a smaller key
        pos = fill;
        while (pos > 0 && slots[pos-1].key < key) begin
          slots[pos] = slots[pos-1];
          pos--;
        end
        slots[pos].id  = id;
        slots[pos].key = key;
        fill++;
      end
    end else if (fill == 0) begin
      r.status = spq_pkg::ST_EMPTY;
    end else begin
      r.served_id  = slots[0].id;
      r.served_key = slots[0].key;
      for (int i = 1; i < fill; i++) slots[i-1] = slots[i];
      fill--;
    end
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    spq_pkg::result_t want;
    if (rst) begin
      fill = 0;
      expected_results.delete();
    end else begin
      if (req.valid && req.ready) begin
        want = apply_request(req.kind, req.entry_id, req.entry_key);
        expected_results.push_back(want);
        request_count++;
        if (req.kind == spq_pkg::KIND_REMOVE && want.status == spq_pkg::ST_DONE)
          serve_count++;
        if (fill > fill_peak) fill_peak = fill;
      end
      if (rsp.valid && rsp.ready) begin
        result_count++;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected transaction on rsp: status %0d id %h key %h",
                     rsp.status, rsp.served_id, rsp.served_key);
        end else begin
          want = expected_results.pop_front();
          if (rsp.status !== want.status || rsp.served_id !== want.served_id ||
              rsp.served_key !== want.served_key) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch on result %0d: expected %s id %h key %h, got %0d id %h key %h",
                       result_count, want.status.name(), want.served_id,
                       want.served_key, rsp.status, rsp.served_id, rsp.served_key);
          end
          case (want.status)
            spq_pkg::ST_FULL:  refuse_full++;
            spq_pkg::ST_EMPTY: refuse_empty++;
            default:           ;
          endcase
        end
      end
    end
    failures      <= fail_count;
    pending       <= expected_results.size();
    requests_seen <= request_count;
    served_count  <= serve_count;
    full_count    <= refuse_full;
    empty_count   <= refuse_empty;
    peak_fill     <= fill_peak;
  end

endmodule

@@ test/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 8;
  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  sorted_priority_queue #(.QUEUE_DEPTH(DEPTH)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  int unsigned failures;
  int unsigned pending;
  int unsigned requests_seen;
  int unsigned served_count;
  int unsigned full_count;
  int unsigned empty_count;
  int unsigned peak_fill;

  spq_checker #(.QUEUE_DEPTH(DEPTH)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .failures      (failures),
    .pending       (pending),
    .requests_seen (requests_seen),
    .served_count  (served_count),
    .full_count    (full_count),
    .empty_count   (empty_count),
    .peak_fill     (peak_fill)
  );

  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;
  logic        hold_trigger;
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // response side: random stalls plus one long hold-off
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_trigger) begin
        rsp_ch.ready <= 1'b0;
        hold_left = HOLD_CYCLES;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  task automatic send_request(logic kind, logic [15:0] id, logic [7:0] key);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.kind      <= kind;
    req_ch.entry_id  <= id;
    req_ch.entry_key <= key;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // bursts are drawn at random from draining, balanced and filling mixes,
  // with narrow or full key ranges; the narrow ones produce many ties
  task automatic send_random(int count);
    int unsigned insert_pct;
    int unsigned key_span;
    logic        kind;
    logic [7:0]  key;
    for (int i = 0; i < count; i++) begin
      if (i % 24 == 0) begin
        case ($urandom_range(2))
          0:       insert_pct = 25;
          1:       insert_pct = 50;
          default: insert_pct = 80;
        endcase
        case ($urandom_range(2))
          0:       key_span = 3;
          1:       key_span = 15;
          default: key_span = 255;
        endcase
      end
      kind = ($urandom_range(99) < insert_pct) ? spq_pkg::KIND_INSERT : spq_pkg::KIND_REMOVE;
      key  = 8'($urandom_range(key_span));
      if (key_span != 255 && $urandom_range(1) == 1) key = 8'hff - key;
      send_request(kind, 16'($urandom_range(16'hffff)), key);
    end
  endtask

  initial begin : stimulus
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.kind       <= spq_pkg::KIND_INSERT;
    req_ch.entry_id   <= '0;
    req_ch.entry_key  <= '0;
    hold_trigger      <= 1'b0;
    sender_idle_pct   <= 11;
    receiver_idle_pct <= 75;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty removal, extremes, ties, full refusal, full drain
    send_request(spq_pkg::KIND_REMOVE, 16'hffff, 8'hff);
    send_request(spq_pkg::KIND_INSERT, 16'hffff, 8'hff);
    send_request(spq_pkg::KIND_INSERT, 16'h0000, 8'h00);
    send_request(spq_pkg::KIND_INSERT, 16'haaaa, 8'h80);
    send_request(spq_pkg::KIND_INSERT, 16'h5555, 8'h80);
    send_request(spq_pkg::KIND_INSERT, 16'h0001, 8'h80);
    send_request(spq_pkg::KIND_INSERT, 16'h8000, 8'h7f);
    send_request(spq_pkg::KIND_INSERT, 16'h1234, 8'hff);
    send_request(spq_pkg::KIND_INSERT, 16'h00ff, 8'h01);
    send_request(spq_pkg::KIND_INSERT, 16'hbeef, 8'hff);
    send_request(spq_pkg::KIND_INSERT, 16'h0f0f, 8'h00);
    repeat (9) send_request(spq_pkg::KIND_REMOVE, 16'h0000, 8'h00);

    send_random(480);
    sender_idle_pct   <= 75;
    receiver_idle_pct <= 11;
    send_random(480);
    sender_idle_pct   <= 0;
    receiver_idle_pct <= 0;

    req_ch.valid <= 1'b0;
    hold_trigger <= 1'b1;
    @(posedge clk);
    hold_trigger <= 1'b0;
    send_random(470);
    req_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d requests, %0d entries served, %0d inserts refused full, %0d removals on empty",
             requests_seen, served_count, full_count, empty_count);
    $display("queue reached %0d of %0d entries, %0d failures", peak_fill, DEPTH, failures);
    if (failures == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/spq_pkg.sv
design/spq_if.sv
design/spq_cell.sv
design/spq_out_buf.sv
design/sorted_priority_queue.sv
test/spq_checker.sv
test/testbench.sv
